FILE: hdl/block_median_filter_macros.svh
// ----------------------------------------------------------------------------
// Block median filter assertion macros
// Shared concurrent assertion forms used by the filter's modules.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MEDIAN_FILTER_MACROS_SVH
`define BLOCK_MEDIAN_FILTER_MACROS_SVH

// condition holds on every clock edge outside reset
`define BMF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define BMF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define BMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// Block median filter package
// Payload types, chain link types and register map constants.
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int MAX_WINDOW_DEF = 16;
   localparam int SAMPLE_W       = 32;
   localparam int WINDOW_W       = 5;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd5;

   // register map: one 32-bit register, word addressed
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WINDOW = 1'b0;

   // command codes
   localparam logic CMD_PUSH    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic       command;
      sample_type sample;
   } bmf_req_type;

   typedef struct packed {
      sample_type median;
      logic       ready_res;
   } bmf_rsp_type;

   // control broadcast to every sort cell
   typedef struct packed {
      logic clear;
      logic insert;
   } bmf_ctl_type;

   // what a cell hands to its upper neighbor
   typedef struct packed {
      logic       take;
      logic       valid;
      sample_type value;
   } bmf_link_type;

endpackage

FILE: hdl/bmf_cell.sv
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one entry of the ascending sorted block; takes the broadcast key or
// the entry of its lower neighbor when an insert lands at or below it.
// ----------------------------------------------------------------------------
`include "block_median_filter_macros.svh"

module bmf_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  bmf_pkg::bmf_ctl_type  ctl,
   input  bmf_pkg::sample_type   key,
   input  bmf_pkg::bmf_link_type link_in,
   output bmf_pkg::bmf_link_type link_out
);
   import bmf_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   sample_type value_ff;
   sample_type value_in;
   logic       take_w;

   // key belongs at or below this cell
   assign take_w = !valid_ff || (value_ff > key);

   assign link_out.take  = take_w;
   assign link_out.valid = valid_ff;
   assign link_out.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert && take_w) begin
         if (link_in.take) begin
            // shift up from the lower neighbor
            valid_in = link_in.valid;
            value_in = link_in.value;
         end else begin
            valid_in = 1'b1;
            value_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   `BMF_ASSERT_NEXT(a_cell_clear, clock, reset, ctl.clear, !valid_ff)
   `BMF_ASSERT_NEXT(a_cell_hold, clock, reset, !ctl.clear && !ctl.insert && valid_ff, valid_ff)
   `BMF_ASSERT_NEXT(a_cell_fill, clock, reset,
                    ctl.insert && !ctl.clear && !link_in.take && take_w, valid_ff)

endmodule

FILE: hdl/bmf_sort_chain.sv
// ----------------------------------------------------------------------------
// Insertion sort chain
// A row of sort cells that keeps the current block in ascending order and
// reads out the entry at a selected rank.
// ----------------------------------------------------------------------------
`include "block_median_filter_macros.svh"

module bmf_sort_chain #(
   parameter int DEPTH = bmf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bmf_pkg::bmf_ctl_type                     ctl,
   input  bmf_pkg::sample_type                      key,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] sel,
   output bmf_pkg::sample_type                      median
);
   import bmf_pkg::*;

   bmf_link_type link_w [DEPTH+1];
   sample_type   cell_value_w [DEPTH];
   logic [DEPTH-1:0] valid_w;
   logic [DEPTH-1:0] order_ok_w;

   // nothing sits below the first cell
   assign link_w[0].take  = 1'b0;
   assign link_w[0].valid = 1'b0;
   assign link_w[0].value = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bmf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key      (key),
         .link_in  (link_w[i]),
         .link_out (link_w[i+1])
      );
      assign cell_value_w[i] = link_w[i+1].value;
      assign valid_w[i]      = link_w[i+1].valid;
   end

   assign median = cell_value_w[sel];

   always_comb begin
      order_ok_w[0] = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         order_ok_w[i] = !valid_w[i] || (cell_value_w[i-1] <= cell_value_w[i]);
      end
   end

   // occupied cells are a contiguous run from the bottom, in ascending order
   `BMF_ASSERT_ALWAYS(a_chain_packed, clock, reset, (valid_w & (valid_w + DEPTH'(1))) == '0)
   `BMF_ASSERT_ALWAYS(a_chain_sorted, clock, reset, &order_ok_w)
   `BMF_ASSERT_NEXT(a_chain_clear, clock, reset, ctl.clear, valid_w == '0)

endmodule

FILE: hdl/block_median_filter.sv
// ----------------------------------------------------------------------------
// Block median filter
// Non-overlapping block median of signed 32-bit samples, one result per item.
// ----------------------------------------------------------------------------
// Each push is written to the sample store and inserted into a chain of sort
// cells that keeps the block in ascending order; the chain takes one key per
// cycle. A push that leaves the block incomplete, and a restart, give an
// all-zero response. The push that completes the block does the insert,
// then reads the entry at rank size/2 from the chain in ST_MEDIAN. If the
// window register was lowered to or below the fill level mid-block, the
// chain is rebuilt in ST_REBUILD from the first size store entries, one
// entry per cycle. A result sits in an output register; a new transfer is
// taken when the block is idle and that register is empty or draining.
// Window size 0 acts as 1 and sizes above MAX_WINDOW saturate.
// ----------------------------------------------------------------------------
`include "block_median_filter_macros.svh"

module block_median_filter #(
   parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bmf_pkg::bmf_req_type               req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bmf_pkg::bmf_rsp_type               rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bmf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bmf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                              pready
);
   import bmf_pkg::*;

   localparam int FW = $clog2(MAX_WINDOW + 1);
   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = (FW > WINDOW_W) ? FW : WINDOW_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REBUILD,
      ST_MEDIAN
   } state_type;

   state_type           state_ff, state_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bmf_rsp_type         rsp_payload_ff, rsp_payload_in;
   logic [WINDOW_W-1:0] window_ff, window_in;

   sample_type          store_ff [MAX_WINDOW];
   sample_type          store_rd_ff;
   logic                store_we;

   logic [CW-1:0]       win_ext_w;
   logic [CW-1:0]       size_ext_w;
   logic [FW-1:0]       size_w;
   logic [IW-1:0]       half_w;
   logic [FW-1:0]       fill_inc_w;
   logic [CSR_IDX_W-1:0] csr_idx_w;
   logic                csr_wr_w;
   logic                req_fire;

   bmf_ctl_type         chain_ctl;
   sample_type          chain_key;
   sample_type          median_w;

   // ---------------------------------------------------------------- config
   assign pready    = 1'b1;
   assign csr_idx_w = paddr[CSR_ADDR_W-1:2];
   assign csr_wr_w  = psel && penable && pwrite;

   always_comb begin
      window_in = window_ff;
      if (csr_wr_w && (csr_idx_w == CSR_IDX_WINDOW)) begin
         window_in = pwdata[WINDOW_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_idx_w == CSR_IDX_WINDOW) begin
         prdata = CSR_DATA_W'(window_ff);
      end
   end

   // effective block size: zero acts as one, saturate at the chain depth
   always_comb begin
      win_ext_w = CW'(window_ff);
      if (win_ext_w == '0) begin
         size_ext_w = CW'(1);
      end else if (win_ext_w > CW'(MAX_WINDOW)) begin
         size_ext_w = CW'(MAX_WINDOW);
      end else begin
         size_ext_w = win_ext_w;
      end
   end

   assign size_w     = size_ext_w[FW-1:0];
   assign half_w     = IW'(size_w >> 1);
   assign fill_inc_w = fill_ff + FW'(1);

   // ---------------------------------------------------------------- control
   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      chain_ctl      = '0;
      chain_key      = req_payload.sample;
      store_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.command)
                  CMD_RESTART: begin
                     fill_in         = '0;
                     chain_ctl.clear = 1'b1;
                     rsp_valid_in    = 1'b1;
                     rsp_payload_in  = '0;
                  end
                  default: begin
                     store_we = 1'b1;
                     if (fill_inc_w < size_w) begin
                        fill_in          = fill_inc_w;
                        chain_ctl.insert = 1'b1;
                        rsp_valid_in     = 1'b1;
                        rsp_payload_in   = '0;
                     end else if (fill_inc_w == size_w) begin
                        fill_in          = '0;
                        chain_ctl.insert = 1'b1;
                        state_in         = ST_MEDIAN;
                     end else begin
                        // window lowered mid-block: re-sort the first size entries
                        fill_in         = '0;
                        chain_ctl.clear = 1'b1;
                        idx_in          = '0;
                        state_in        = ST_REBUILD;
                     end
                  end
               endcase
            end
         end
         ST_REBUILD: begin
            chain_ctl.insert = 1'b1;
            chain_key        = store_rd_ff;
            idx_in           = idx_ff + IW'(1);
            if (FW'(idx_ff) == (size_w - FW'(1))) begin
               state_in = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.median    = median_w;
            rsp_payload_in.ready_res = 1'b1;
            chain_ctl.clear          = 1'b1;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
   end

   // ---------------------------------------------------------------- store
   // the read is one entry ahead, so the rebuild gets a key every cycle
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[fill_ff[IW-1:0]] <= req_payload.sample;
      end
      store_rd_ff <= store_ff[idx_in];
   end

   // ---------------------------------------------------------------- sorter
   bmf_sort_chain #(
      .DEPTH (MAX_WINDOW)
   ) u_sort_chain (
      .clock  (clock),
      .reset  (reset),
      .ctl    (chain_ctl),
      .key    (chain_key),
      .sel    (half_w),
      .median (median_w)
   );

   `BMF_ASSERT_IMPLIES(a_busy_no_rsp, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff)
   `BMF_ASSERT_NEXT(a_median_out, clock, reset, state_ff == ST_MEDIAN,
                    rsp_valid_ff && rsp_payload_ff.ready_res)
   `BMF_ASSERT_IMPLIES(a_partial_zero, clock, reset, rsp_valid_ff && !rsp_payload_ff.ready_res,
                       rsp_payload_ff.median == '0)

endmodule
